[src/gepp_pkg.sv]
// Shared types and helpers for the Gaussian elimination solver.
// Used by gepp_div and gauss_elimination_partial_pivot_solver; depends on nothing.
`default_nettype none
package gepp_pkg;

  localparam int DATA_W    = 32;
  localparam int MAX_ORDER = 16;

  // Request commands carried on the input tuser.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  typedef logic signed [DATA_W-1:0] fix_t;

  localparam fix_t FIX_MAX = 32'sh7FFF_FFFF;
  localparam fix_t FIX_MIN = 32'sh8000_0000;

  // Saturate a wide signed value to the 32-bit range.
  function automatic fix_t sat_fix(input logic signed [71:0] v);
    fix_t r;
    if (v > 72'sh7FFF_FFFF) begin
      r = FIX_MAX;
    end else if (v < -72'sh8000_0000) begin
      r = FIX_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[src/gauss_elimination_partial_pivot_solver.sv]
// A load writes the matrix memory directly. A solve copies the rows into the working
// memory, then for each column searches the rows for the pivot, forms each row multiplier
// in the divider and updates the row elements in the shared multiplier, then runs back
// substitution, one division per row, then emits the results. The block takes one request
// at a time; it is not ready while solving.
// Reset (synchronous, rst high) clears the sequencer, the order register to 2, the row
// permutation to identity and the output valid; the matrix and solution memories keep data.
// Top level: matrix memory, working memory, sequencer; depends on gepp_pkg, gepp_div.
`default_nettype none
module gauss_elimination_partial_pivot_solver #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: matrix_order.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // row_index[3:0], column_index[8:4], element_value[40:9]
  input  wire logic        s_tuser,  // command
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // unknown_index[3:0], solution_value[35:4]
  output logic             m_tuser,  // singular
  output logic             m_tlast   // last
);
  import gepp_pkg::*;

  localparam int STRIDE = MAX_ORDER + 1;
  localparam int DEPTH  = MAX_ORDER * STRIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int PW     = $clog2(MAX_ORDER);
  localparam int CW     = $clog2(MAX_ORDER + 1);
  localparam int OW     = (CW > 5) ? CW : 5;
  localparam int QW     = 64 - FRAC_BITS;
  localparam int SW     = QW + PW;
  localparam logic [63:0] BIAS = (64'd1 << FRAC_BITS) - 64'd1;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_COPY     = 5'd1;
  localparam logic [4:0] ST_PIV_INIT = 5'd2;
  localparam logic [4:0] ST_PIV_RD   = 5'd3;
  localparam logic [4:0] ST_PIV_CMP  = 5'd4;
  localparam logic [4:0] ST_PIV_END  = 5'd5;
  localparam logic [4:0] ST_ROW      = 5'd6;
  localparam logic [4:0] ST_ROW_RD   = 5'd7;
  localparam logic [4:0] ST_ROW_DIV  = 5'd8;
  localparam logic [4:0] ST_ROW_WAIT = 5'd9;
  localparam logic [4:0] ST_UPD_RD   = 5'd10;
  localparam logic [4:0] ST_UPD_MUL  = 5'd11;
  localparam logic [4:0] ST_UPD_TR   = 5'd12;
  localparam logic [4:0] ST_UPD_WR   = 5'd13;
  localparam logic [4:0] ST_CHK_RD   = 5'd14;
  localparam logic [4:0] ST_CHK      = 5'd15;
  localparam logic [4:0] ST_BS       = 5'd16;
  localparam logic [4:0] ST_BS_LOOP  = 5'd17;
  localparam logic [4:0] ST_BS_MUL   = 5'd18;
  localparam logic [4:0] ST_BS_TR    = 5'd19;
  localparam logic [4:0] ST_BS_ACC   = 5'd20;
  localparam logic [4:0] ST_BS_RHS   = 5'd21;
  localparam logic [4:0] ST_BS_DIV   = 5'd22;
  localparam logic [4:0] ST_BS_WAIT  = 5'd23;
  localparam logic [4:0] ST_OUT_INIT = 5'd24;
  localparam logic [4:0] ST_OUT_RD   = 5'd25;
  localparam logic [4:0] ST_OUT_SHOW = 5'd26;
  localparam logic [4:0] ST_OUT_WAIT = 5'd27;

  function automatic logic [AW-1:0] addr_of(input logic [OW-1:0] row,
                                            input logic [OW-1:0] col);
    return AW'(AW'(row) * AW'(STRIDE) + AW'(col));
  endfunction

  // Product divided by 2^FRAC_BITS, truncated toward zero.
  function automatic logic signed [QW-1:0] trunc_q(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (p[63] ? $signed(BIAS) : 64'sd0);
    return t[63:FRAC_BITS];
  endfunction

  logic [4:0]    state;
  logic [4:0]    order;
  logic [CW-1:0] n;
  logic [CW-1:0] i, j, r, c;
  logic [PW-1:0] best_row, prow, jr, ir;
  logic [32:0]   bestmag;
  logic [32:0]   m_cur;
  fix_t          piv, mulv, old, acc;
  logic          singular;
  logic signed [63:0]   prod;
  logic signed [QW-1:0] qm;
  logic signed [SW-1:0] sum;

  logic [PW-1:0] perm [MAX_ORDER];
  logic [PW-1:0] perm_addr;
  logic [PW-1:0] perm_q;

  fix_t          matrix_mem [DEPTH];
  fix_t          work_mem [DEPTH];
  fix_t          sol_mem [MAX_ORDER];
  fix_t          mat_rd, work_rd, sol_rd;
  logic [AW-1:0] work_raddr, work_waddr, cp_k, cp_addr, cp_total;
  logic          work_we, cp_v;
  fix_t          work_wdata;
  logic [PW-1:0] sol_raddr;

  logic          div_start, div_done;
  fix_t          div_a, div_b, div_q;
  fix_t          op_a;

  logic          in_acc;
  logic [3:0]    ld_row;
  logic [4:0]    ld_col;
  fix_t          ld_val;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign ld_row    = s_tdata[3:0];
  assign ld_col    = s_tdata[8:4];
  assign ld_val    = s_tdata[40:9];
  assign cp_total  = AW'(AW'(n) * AW'(STRIDE));

  // Order in use, clamped to 2..MAX_ORDER.
  always_comb begin
    if (OW'(order) < OW'(2)) begin
      n = CW'(2);
    end else if (OW'(order) > OW'(MAX_ORDER)) begin
      n = CW'(MAX_ORDER);
    end else begin
      n = CW'(order);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= 5'd2;
    end else if (cfg_valid && cfg_ready) begin
      order <= cfg_data;
    end
  end

  // Loaded matrix; read only by the copy sweep.
  always_ff @(posedge clk) begin
    if (in_acc && (s_tuser == CMD_LOAD) && (OW'(ld_row) < OW'(n)) &&
        (OW'(ld_col) <= OW'(n))) begin
      matrix_mem[addr_of(OW'(ld_row), OW'(ld_col))] <= ld_val;
    end
    mat_rd <= matrix_mem[cp_k];
  end

  // Working copy: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    work_rd <= work_mem[work_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_BS_WAIT && div_done) begin
      sol_mem[i[PW-1:0]] <= div_q;
    end
    sol_rd <= sol_mem[sol_raddr];
  end

  assign perm_q = perm[perm_addr];

  // Address selection for the shared read ports.
  always_comb begin
    perm_addr  = i[PW-1:0];
    work_raddr = '0;
    sol_raddr  = j[PW-1:0];
    case (state)
      ST_PIV_RD: begin
        perm_addr  = r[PW-1:0];
        work_raddr = addr_of(OW'(perm_q), OW'(i));
      end
      ST_PIV_CMP: perm_addr = r[PW-1:0];
      ST_ROW:     perm_addr = j[PW-1:0];
      ST_ROW_RD:  work_raddr = addr_of(OW'(jr), OW'(i));
      ST_UPD_RD:  work_raddr = addr_of(OW'(prow), OW'(c));
      ST_UPD_MUL: work_raddr = addr_of(OW'(jr), OW'(c));
      ST_CHK_RD: begin
        perm_addr  = PW'(n - CW'(1));
        work_raddr = addr_of(OW'(perm_q), OW'(n - CW'(1)));
      end
      ST_BS_LOOP: work_raddr = (j < n) ? addr_of(OW'(ir), OW'(j)) : addr_of(OW'(ir), OW'(n));
      ST_BS_RHS:  work_raddr = addr_of(OW'(ir), OW'(i));
      default: ;
    endcase
  end

  // Write port: copy sweep or element update.
  always_comb begin
    work_we    = cp_v;
    work_waddr = cp_addr;
    work_wdata = mat_rd;
    if (state == ST_UPD_WR) begin
      work_we    = 1'b1;
      work_waddr = addr_of(OW'(jr), OW'(c));
      work_wdata = sat_fix(72'(old) - 72'(qm));
    end
  end

  // Magnitude for the pivot search.
  assign m_cur = work_rd[31] ? (33'd0 - {work_rd[31], work_rd}) : {1'b0, work_rd};

  // Divider operands.
  always_comb begin
    div_start = (state == ST_ROW_DIV) || (state == ST_BS_DIV);
    div_a     = (state == ST_BS_DIV) ? acc : work_rd;
    div_b     = (state == ST_BS_DIV) ? work_rd : piv;
    op_a      = (state == ST_BS_MUL) ? sol_rd : mulv;
  end

  gepp_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // Shared multiplier with its result register.
  always_ff @(posedge clk) begin
    if (state == ST_UPD_MUL || state == ST_BS_MUL) begin
      prod <= op_a * work_rd;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cp_v     <= 1'b0;
      m_tvalid <= 1'b0;
      singular <= 1'b0;
      for (int k = 0; k < MAX_ORDER; k++) begin
        perm[k] <= PW'(k);
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc && (s_tuser == CMD_SOLVE)) begin
            cp_k     <= '0;
            singular <= 1'b0;
            for (int k = 0; k < MAX_ORDER; k++) begin
              perm[k] <= PW'(k);
            end
            state <= ST_COPY;
          end
        end
        ST_COPY: begin
          if (cp_k < cp_total) begin
            cp_v    <= 1'b1;
            cp_addr <= cp_k;
            cp_k    <= cp_k + AW'(1);
          end else begin
            cp_v  <= 1'b0;
            i     <= '0;
            state <= ST_PIV_INIT;
          end
        end
        ST_PIV_INIT: begin
          r       <= i;
          bestmag <= '0;
          state   <= ST_PIV_RD;
        end
        ST_PIV_RD: state <= ST_PIV_CMP;
        ST_PIV_CMP: begin
          if (m_cur > bestmag) begin
            bestmag  <= m_cur;
            best_row <= perm_q;
            piv      <= work_rd;
            j        <= r;
          end
          if (r + CW'(1) < n) begin
            r     <= r + CW'(1);
            state <= ST_PIV_RD;
          end else begin
            state <= ST_PIV_END;
          end
        end
        ST_PIV_END: begin
          if (bestmag == '0) begin
            singular <= 1'b1;
            state    <= ST_OUT_INIT;
          end else begin
            // j holds the position of the best row here.
            if (j != i) begin
              perm[j[PW-1:0]] <= perm_q;
            end
            perm[i[PW-1:0]] <= best_row;
            prow  <= best_row;
            j     <= i + CW'(1);
            state <= ST_ROW;
          end
        end
        ST_ROW: begin
          jr    <= perm_q;
          state <= ST_ROW_RD;
        end
        ST_ROW_RD:  state <= ST_ROW_DIV;
        ST_ROW_DIV: state <= ST_ROW_WAIT;
        ST_ROW_WAIT: begin
          if (div_done) begin
            mulv  <= div_q;
            c     <= i;
            state <= ST_UPD_RD;
          end
        end
        ST_UPD_RD:  state <= ST_UPD_MUL;
        ST_UPD_MUL: state <= ST_UPD_TR;
        ST_UPD_TR: begin
          qm    <= trunc_q(prod);
          old   <= work_rd;
          state <= ST_UPD_WR;
        end
        ST_UPD_WR: begin
          if (c < n) begin
            c     <= c + CW'(1);
            state <= ST_UPD_RD;
          end else if (j + CW'(1) < n) begin
            j     <= j + CW'(1);
            state <= ST_ROW;
          end else if (i + CW'(2) < n) begin
            i     <= i + CW'(1);
            state <= ST_PIV_INIT;
          end else begin
            state <= ST_CHK_RD;
          end
        end
        ST_CHK_RD: state <= ST_CHK;
        ST_CHK: begin
          if (work_rd == '0) begin
            singular <= 1'b1;
            state    <= ST_OUT_INIT;
          end else begin
            i     <= n - CW'(1);
            state <= ST_BS;
          end
        end
        ST_BS: begin
          ir    <= perm_q;
          sum   <= '0;
          j     <= i + CW'(1);
          state <= ST_BS_LOOP;
        end
        ST_BS_LOOP: state <= (j < n) ? ST_BS_MUL : ST_BS_RHS;
        ST_BS_MUL:  state <= ST_BS_TR;
        ST_BS_TR: begin
          qm    <= trunc_q(prod);
          state <= ST_BS_ACC;
        end
        ST_BS_ACC: begin
          sum   <= sum + SW'(qm);
          j     <= j + CW'(1);
          state <= ST_BS_LOOP;
        end
        ST_BS_RHS: begin
          acc   <= sat_fix(72'(work_rd) - 72'(sum));
          state <= ST_BS_DIV;
        end
        ST_BS_DIV: state <= ST_BS_WAIT;
        ST_BS_WAIT: begin
          if (div_done) begin
            if (i == '0) begin
              state <= ST_OUT_INIT;
            end else begin
              i     <= i - CW'(1);
              state <= ST_BS;
            end
          end
        end
        ST_OUT_INIT: begin
          j     <= '0;
          state <= ST_OUT_RD;
        end
        ST_OUT_RD: state <= ST_OUT_SHOW;
        ST_OUT_SHOW: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {4'd0, (singular ? 32'd0 : sol_rd), 4'(j)};
          m_tuser  <= singular;
          m_tlast  <= (j == n - CW'(1));
          state    <= ST_OUT_WAIT;
        end
        ST_OUT_WAIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              state <= ST_IDLE;
            end else begin
              j     <= j + CW'(1);
              state <= ST_OUT_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A result is never offered while a new request can be taken.
  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  // The last result of a run returns the block to idle.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("block not idle after the last result");

  // A singular run reports zero values.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[35:4] == 32'd0))
    else $error("singular result carries a value");

  // The divider is only started from the two division states.
  assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == ST_ROW_WAIT || state == ST_BS_WAIT))
    else $error("divider started outside a division step");

endmodule
`default_nettype wire

[src/gepp_div.sv]
// Iterative fixed-point divider: (a * 2^FRAC_BITS) / b, truncated, saturated.
// One quotient bit per cycle; depends on gepp_pkg.
`default_nettype none
module gepp_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire gepp_pkg::fix_t dividend,
  input  wire gepp_pkg::fix_t divisor,
  output logic               done,
  output gepp_pkg::fix_t     quotient
);
  import gepp_pkg::*;

  localparam int NW = 33 + FRAC_BITS;
  localparam int KW = $clog2(NW + 1);
  localparam logic [NW-1:0] POS_LIM = NW'(64'h7FFF_FFFF);
  localparam logic [NW-1:0] NEG_LIM = NW'(64'h8000_0000);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state;
  logic [NW-1:0] num;
  logic [NW-1:0] q;
  logic [32:0]   den;
  logic [32:0]   rem;
  logic [KW-1:0] cnt;
  logic          neg;
  logic [33:0]   rem_s;
  logic [32:0]   a_mag;
  logic [32:0]   b_mag;

  // Operand magnitudes.
  always_comb begin
    a_mag = dividend[31] ? (33'd0 - {dividend[31], dividend}) : {1'b0, dividend};
    b_mag = divisor[31] ? (33'd0 - {divisor[31], divisor}) : {1'b0, divisor};
    rem_s = {rem, num[NW-1]};
  end

  // Restoring division, one bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            num   <= {a_mag, FRAC_BITS'(0)};
            den   <= b_mag;
            neg   <= dividend[31] ^ divisor[31];
            rem   <= '0;
            q     <= '0;
            cnt   <= KW'(NW);
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (rem_s >= {1'b0, den}) begin
            rem <= 33'(rem_s - {1'b0, den});
            q   <= {q[NW-2:0], 1'b1};
          end else begin
            rem <= rem_s[32:0];
            q   <= {q[NW-2:0], 1'b0};
          end
          num <= {num[NW-2:0], 1'b0};
          cnt <= cnt - KW'(1);
          if (cnt == KW'(1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!neg) begin
            quotient <= (q > POS_LIM) ? FIX_MAX : q[31:0];
          end else begin
            quotient <= (q > NEG_LIM) ? FIX_MIN : 32'(NW'(0) - q);
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[sim/gauss_elimination_partial_pivot_solver_tb.sv]
// Testbench for the fixed-point Gaussian elimination solver with partial pivoting.
// Loads matrices, issues solve requests and checks every solution component against
// a behavioral predictor; depends on gepp_pkg and gauss_elimination_partial_pivot_solver.
`timescale 1ns / 1ps

module gauss_elimination_partial_pivot_solver_tb;
  import gepp_pkg::*;

  localparam int MAXN = 16;
  localparam int FRAC = 16;

  typedef struct packed {
    logic [3:0] idx;
    fix_t value;
    logic singular;
    logic last;
  } solution_t;

  int mismatches = 0;

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Scoreboard: tracks the loaded matrix and order and predicts each solve.
  class solver_scoreboard;
    fix_t mat [MAXN][MAXN+1];
    fix_t sol [MAXN];
    int order_reg;
    solution_t pending[$];
    int errors;
    int solves;
    int results;

    function new();
      order_reg = 2;
      errors = 0;
      solves = 0;
      results = 0;
      for (int r = 0; r < MAXN; r++) begin
        sol[r] = 0;
        for (int c = 0; c <= MAXN; c++) mat[r][c] = 0;
      end
    endfunction

    function int order_used();
      int n;
      n = order_reg;
      if (n < 2) n = 2;
      if (n > MAXN) n = MAXN;
      return n;
    endfunction

    function fix_t sat(longint v);
      if (v > 64'sh7FFF_FFFF) return FIX_MAX;
      if (v < -64'sh8000_0000) return FIX_MIN;
      return fix_t'(v);
    endfunction

    // Truncating fixed-point product, not saturated.
    function longint fmul(fix_t a, fix_t b);
      longint p;
      p = longint'(a) * longint'(b);
      return p / (64'sd1 <<< FRAC);
    endfunction

    function fix_t fdiv(longint a, fix_t b);
      return sat((a * (64'sd1 <<< FRAC)) / longint'(b));
    endfunction

    // Note an accepted request; a solve pushes its predicted components.
    function void note_request(logic cmd, logic [3:0] row, logic [4:0] col, fix_t v);
      int n, best, prow, jr, ir;
      longint bestmag, m, sum;
      fix_t w [MAXN][MAXN+1];
      int perm [MAXN];
      int t;
      fix_t mulv, acc;
      bit sing;
      solution_t s;
      n = order_used();
      if (cmd == CMD_LOAD) begin
        if (row < n && col <= n) mat[row][col] = v;
        return;
      end
      sing = 0;
      for (int r = 0; r < n; r++) begin
        perm[r] = r;
        for (int c = 0; c <= n; c++) w[r][c] = mat[r][c];
      end
      for (int i = 0; i + 1 < n && !sing; i++) begin
        best = i;
        bestmag = 0;
        for (int r = i; r < n; r++) begin
          m = longint'(w[perm[r]][i]);
          if (m < 0) m = -m;
          if (m > bestmag) begin
            bestmag = m;
            best = r;
          end
        end
        if (bestmag == 0) begin
          sing = 1;
          break;
        end
        t = perm[best];
        perm[best] = perm[i];
        perm[i] = t;
        prow = perm[i];
        for (int j = i + 1; j < n; j++) begin
          jr = perm[j];
          mulv = fdiv(longint'(w[jr][i]), w[prow][i]);
          for (int c = i; c <= n; c++)
            w[jr][c] = sat(longint'(w[jr][c]) - fmul(mulv, w[prow][c]));
        end
      end
      if (!sing && w[perm[n-1]][n-1] == 0) sing = 1;
      if (!sing) begin
        for (int i = n - 1; i >= 0; i--) begin
          ir = perm[i];
          sum = 0;
          for (int j = i + 1; j < n; j++) sum += fmul(w[ir][j], sol[j]);
          acc = sat(longint'(w[ir][n]) - sum);
          sol[i] = fdiv(longint'(acc), w[ir][i]);
        end
      end
      for (int i = 0; i < n; i++) begin
        s.idx = i[3:0];
        s.value = sing ? 32'sd0 : sol[i];
        s.singular = sing;
        s.last = (i == n - 1);
        pending.push_back(s);
      end
      solves++;
    endfunction

    task check_result(solution_t got);
      solution_t want;
      results++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected component idx=%0d", got.idx));
        return;
      end
      want = pending.pop_front();
      if (got.idx !== want.idx)
        report_mismatch($sformatf("index got %0d want %0d", got.idx, want.idx));
      if (got.value !== want.value)
        report_mismatch($sformatf("x[%0d] got %h want %h", want.idx, got.value, want.value));
      if (got.singular !== want.singular)
        report_mismatch($sformatf("singular[%0d] got %b want %b", want.idx, got.singular,
                                  want.singular));
      if (got.last !== want.last)
        report_mismatch($sformatf("last[%0d] got %b want %b", want.idx, got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [4:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  solver_scoreboard sb;
  bit hold_off = 0;
  bit stim_done = 0;

  gauss_elimination_partial_pivot_solver dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Send one request, after a random gap, and wait for its acceptance. The valid stays
  // high after a gap of zero so that back-to-back requests need no second assignment.
  task automatic send_request(logic cmd, logic [3:0] row, logic [4:0] col, fix_t v);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {7'd0, v, col, row};
    do @(posedge clk); while (!s_tready);
    sb.note_request(cmd, row, col, v);
  endtask

  task automatic write_order(logic [4:0] n);
    cfg_valid <= 1'b1;
    cfg_data <= n;
    do @(posedge clk); while (!cfg_ready);
    sb.order_reg = n;
    cfg_valid <= 1'b0;
  endtask

  // Stop offering requests, wait until every predicted component has come back,
  // then let the block settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic fix_t rand_value(int kind);
    case (kind)
      0: return fix_t'($urandom);
      1: return fix_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      default: return fix_t'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    endcase
  endfunction

  // Load a full n x (n+1) matrix; mode 1 makes it diagonally heavy, mode 2 zeroes column 0.
  task automatic load_matrix(int n, int mode);
    fix_t v;
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= n; c++) begin
        v = rand_value($urandom_range(0, 4) == 0 ? 0 : 2);
        if (mode == 1 && r == c) v = 32'sh0040_0000 + rand_value(1);
        if (mode == 2 && c == 0) v = 0;
        send_request(CMD_LOAD, r[3:0], c[4:0], v);
      end
  endtask

  // Receiver: random stalls, plus a long hold-off when asked.
  initial begin
    solution_t got;
    int wait_cycles;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got.idx = m_tdata[3:0];
        got.value = m_tdata[35:4];
        got.singular = m_tuser;
        got.last = m_tlast;
        sb.check_result(got);
        m_tready <= 1'b0;
        wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
      end else if (!m_tready) begin
        if (hold_off) m_tready <= 1'b0;
        else if (wait_cycles > 0) wait_cycles--;
        else m_tready <= 1'b1;
      end
    end
  end

  // Stimulus.
  initial begin
    int n;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: order 2, extremes, singular column, tie on pivot, ignored loads.
    send_request(CMD_LOAD, 4'd0, 5'd0, 32'sh0001_0000);
    send_request(CMD_LOAD, 4'd0, 5'd1, 32'sh0002_0000);
    send_request(CMD_LOAD, 4'd0, 5'd2, FIX_MAX);
    send_request(CMD_LOAD, 4'd1, 5'd0, -32'sh0001_0000);
    send_request(CMD_LOAD, 4'd1, 5'd1, 32'sh0003_0000);
    send_request(CMD_LOAD, 4'd1, 5'd2, FIX_MIN);
    send_request(CMD_LOAD, 4'd15, 5'd31, 32'sh1234_5678);
    send_request(CMD_LOAD, 4'd1, 5'd16, -32'sd1);
    send_request(CMD_SOLVE, 4'd0, 5'd0, 32'sd0);
    send_request(CMD_LOAD, 4'd0, 5'd2, 32'sh0000_0001);
    send_request(CMD_LOAD, 4'd1, 5'd2, 32'sh0000_0000);
    send_request(CMD_SOLVE, 4'd15, 5'd31, -32'sd1);
    send_request(CMD_LOAD, 4'd0, 5'd0, 32'sd0);
    send_request(CMD_LOAD, 4'd1, 5'd0, 32'sd0);
    send_request(CMD_SOLVE, 4'd0, 5'd0, 32'sd0);
    send_request(CMD_LOAD, 4'd0, 5'd0, FIX_MIN);
    send_request(CMD_LOAD, 4'd1, 5'd0, FIX_MIN);
    send_request(CMD_LOAD, 4'd0, 5'd1, FIX_MAX);
    send_request(CMD_LOAD, 4'd1, 5'd1, FIX_MAX);
    send_request(CMD_SOLVE, 4'd0, 5'd0, 32'sd0);
    drain();

    // Long receiver hold-off while solves keep arriving.
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int k = 0; k < 4; k++) send_request(CMD_SOLVE, 4'd0, 5'd0, 32'sd0);
        s_tvalid <= 1'b0;
      end
    join
    drain();

    // Random phases over several orders; order 0 clamps up to 2.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: n = 3;
        1: n = 0;
        2: n = 7;
        3: n = 5;
        default: n = $urandom_range(2, 5);
      endcase
      write_order(n[4:0]);
      n = sb.order_used();
      load_matrix(n, (ph % 3 == 2) ? 2 : 1);
      send_request(CMD_SOLVE, 4'($urandom), 5'($urandom), fix_t'($urandom));
      if (n <= 4) begin
        for (int k = 0; k < 6; k++)
          send_request(CMD_LOAD, 4'($urandom_range(0, n - 1)),
                       5'($urandom_range(0, n)), rand_value($urandom_range(0, 2)));
        send_request(CMD_LOAD, 4'($urandom_range(n, 15)), 5'($urandom), fix_t'($urandom));
        send_request(CMD_SOLVE, 4'd0, 5'd0, 32'sd0);
      end
      drain();
    end
    stim_done = 1;
    repeat (100) @(posedge clk);
    $display("Ran %0d solve requests with random loads and stalls, checked %0d components.",
             sb.solves, sb.results);
    if (mismatches == 0 && sb.pending.size() == 0) begin
      $display("** gauss_elimination_partial_pivot_solver: PASSED **");
    end else begin
      $display("** gauss_elimination_partial_pivot_solver: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("Timeout with %0d components outstanding.", sb.pending.size());
    $display("** gauss_elimination_partial_pivot_solver: FAILED **");
    $finish;
  end

endmodule
